FILE: hw/rtl/inflate_window_copy_engine_assert.svh
// Assertion macros shared by the window copy engine RTL.
// Every use names the clock clk of the module; IWCE_ASSERT also names its active-low reset rst_n.
`ifndef INFLATE_WINDOW_COPY_ENGINE_ASSERT_SVH
`define INFLATE_WINDOW_COPY_ENGINE_ASSERT_SVH

// Property checked outside reset only.
`define IWCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define IWCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/iwce_pkg.sv
package iwce_pkg;

  // Window and lane geometry.
  localparam int WINDOW_SIZE = 32768;
  localparam int ADDR_W      = $clog2(WINDOW_SIZE);
  localparam int SEEN_W      = $clog2(WINDOW_SIZE + 1);
  localparam int LANE_BYTES  = 8;
  localparam int LANE_W      = LANE_BYTES * 8;
  localparam int FILL_W      = $clog2(LANE_BYTES + 1);
  localparam int LANE_IDX_W  = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;

  // Match length spans 3 to 258, match distance 1 to 32768.
  localparam int LEN_W  = 9;
  localparam int DIST_W = 16;

  // Symbol codes.
  localparam logic [8:0] EOB_CODE        = 9'd256;
  localparam logic [8:0] LEN_CODE_LIMIT  = 9'd286;
  localparam logic [4:0] DIST_CODE_LIMIT = 5'd30;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_LEN_CODE  = 2'd1,
    ERR_DIST_CODE = 2'd2,
    ERR_DIST_FAR  = 2'd3
  } err_code_t;

  typedef struct packed {
    logic [8:0]  litlen_code;
    logic [4:0]  length_extra;
    logic [4:0]  dist_code;
    logic [12:0] dist_extra;
    logic        final_block;
  } in_item_t;

  typedef struct packed {
    logic [LANE_W-1:0] out_bytes;
    logic [3:0]        byte_count;
    logic              last;
    logic              end_of_block;
    err_code_t         error_code;
  } out_item_t;

  // Request bundle towards the history window.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } win_req_t;

  // Length base for length codes 257 to 285, indexed from 0.
  function automatic logic [LEN_W-1:0] len_base(input logic [4:0] idx);
    logic [LEN_W-1:0] v;
    unique case (idx)
      5'd0:  v = 9'd3;    5'd1:  v = 9'd4;    5'd2:  v = 9'd5;    5'd3:  v = 9'd6;
      5'd4:  v = 9'd7;    5'd5:  v = 9'd8;    5'd6:  v = 9'd9;    5'd7:  v = 9'd10;
      5'd8:  v = 9'd11;   5'd9:  v = 9'd13;   5'd10: v = 9'd15;   5'd11: v = 9'd17;
      5'd12: v = 9'd19;   5'd13: v = 9'd23;   5'd14: v = 9'd27;   5'd15: v = 9'd31;
      5'd16: v = 9'd35;   5'd17: v = 9'd43;   5'd18: v = 9'd51;   5'd19: v = 9'd59;
      5'd20: v = 9'd67;   5'd21: v = 9'd83;   5'd22: v = 9'd99;   5'd23: v = 9'd115;
      5'd24: v = 9'd131;  5'd25: v = 9'd163;  5'd26: v = 9'd195;  5'd27: v = 9'd227;
      5'd28: v = 9'd258;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Number of extra bits for each length code.
  function automatic logic [2:0] len_bits(input logic [4:0] idx);
    logic [2:0] v;
    priority if (idx < 5'd8 || idx == 5'd28) v = 3'd0;
    else if (idx > 5'd28) v = 3'd0;
    else v = 3'(idx[4:2] - 3'd1);
    return v;
  endfunction

  // Distance base for distance codes 0 to 29.
  function automatic logic [DIST_W-1:0] dist_base(input logic [4:0] idx);
    logic [DIST_W-1:0] v;
    unique case (idx)
      5'd0:  v = 16'd1;     5'd1:  v = 16'd2;     5'd2:  v = 16'd3;
      5'd3:  v = 16'd4;     5'd4:  v = 16'd5;     5'd5:  v = 16'd7;
      5'd6:  v = 16'd9;     5'd7:  v = 16'd13;    5'd8:  v = 16'd17;
      5'd9:  v = 16'd25;    5'd10: v = 16'd33;    5'd11: v = 16'd49;
      5'd12: v = 16'd65;    5'd13: v = 16'd97;    5'd14: v = 16'd129;
      5'd15: v = 16'd193;   5'd16: v = 16'd257;   5'd17: v = 16'd385;
      5'd18: v = 16'd513;   5'd19: v = 16'd769;   5'd20: v = 16'd1025;
      5'd21: v = 16'd1537;  5'd22: v = 16'd2049;  5'd23: v = 16'd3073;
      5'd24: v = 16'd4097;  5'd25: v = 16'd6145;  5'd26: v = 16'd8193;
      5'd27: v = 16'd12289; 5'd28: v = 16'd16385; 5'd29: v = 16'd24577;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Number of extra bits for each distance code.
  function automatic logic [3:0] dist_bits(input logic [4:0] idx);
    logic [3:0] v;
    if (idx < 5'd4 || idx > 5'd29) v = 4'd0;
    else v = 4'(idx[4:1] - 4'd1);
    return v;
  endfunction

endpackage

FILE: hw/rtl/iwce_window.sv
module iwce_window (
  input  logic              clk,
  input  iwce_pkg::win_req_t req,
  output logic [7:0]        rdata
);
  import iwce_pkg::*;

  // History window: one write port and one registered read port.
  logic [7:0] mem [WINDOW_SIZE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: hw/rtl/inflate_window_copy_engine.sv
// LZ77 length/distance stage of an inflate datapath.
// The input channel (in_valid/in_ready/in_item) takes one decoded token: a
// literal, an end-of-block symbol, or a length code with its distance code and
// extra bits. The result channel (out_valid/out_ready/out_item) returns the
// bytes the token produces, up to eight per item, with last set on the final
// item of each token. Literals, end-of-block and errors give a single item.
// A token is taken only while the engine is idle. It is decoded in ST_DECODE;
// a literal, end-of-block or error item then goes out through ST_EMIT, which
// places it in the output register, and the engine returns to idle. For a
// match, each copied byte is read from the history window in ST_READ and
// written at the write position in ST_WRITE, which keeps overlapping copies
// exact, and each item of up to eight bytes is emitted from ST_EMIT.
// A stalled receiver holds the finished item in the output register; the
// engine carries on until it needs to emit the next item and waits there.
// Reset (rst_n low at a clock edge) clears the write position, the count of
// bytes seen, the lane fill count and the output valid flag. The history
// memory is not cleared; distances beyond the bytes seen are rejected, so
// stale data is never read.
`include "inflate_window_copy_engine_assert.svh"

module inflate_window_copy_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iwce_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output iwce_pkg::out_item_t out_item
);
  import iwce_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_READ   = 5'b00100,
    ST_WRITE  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [ADDR_W-1:0] wpos_r, wpos_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              last_r, last_nxt;
  logic              eob_r, eob_nxt;
  err_code_t         err_r, err_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  win_req_t   win_req;
  logic [7:0] win_rdata;

  logic [8:0]        len_off;
  logic [4:0]        len_idx;
  logic [5:0]        len_mask;
  logic [LEN_W-1:0]  len_val;
  logic [13:0]       dist_mask;
  logic [DIST_W-1:0] dist_val;
  logic              dist_far;
  logic [ADDR_W-1:0] src_start;
  logic [SEEN_W-1:0] seen_inc;
  logic              out_free;

  iwce_window u_window (
    .clk   (clk),
    .req   (win_req),
    .rdata (win_rdata)
  );

  // Length and distance from the base tables plus masked extra bits.
  assign len_off   = item_r.litlen_code - EOB_CODE - 9'd1;
  assign len_idx   = len_off[4:0];
  assign len_mask  = (6'd1 << len_bits(len_idx)) - 6'd1;
  assign len_val   = len_base(len_idx) + {4'd0, item_r.length_extra & len_mask[4:0]};
  assign dist_mask = (14'd1 << dist_bits(item_r.dist_code)) - 14'd1;
  assign dist_val  = dist_base(item_r.dist_code)
                   + {3'd0, item_r.dist_extra & dist_mask[12:0]};
  assign dist_far  = dist_val > seen_r;
  assign src_start = wpos_r - dist_val[ADDR_W-1:0];

  // Count of bytes seen saturates at the window size.
  assign seen_inc = (seen_r < SEEN_W'(WINDOW_SIZE)) ? seen_r + SEEN_W'(1) : seen_r;

  assign out_free = !out_valid_r || out_ready;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    wpos_nxt      = wpos_r;
    seen_nxt      = seen_r;
    src_nxt       = src_r;
    remain_nxt    = remain_r;
    lane_nxt      = lane_r;
    fill_nxt      = fill_r;
    last_nxt      = last_r;
    eob_nxt       = eob_r;
    err_nxt       = err_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    win_req       = '0;
    in_ready      = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        lane_nxt  = '0;
        fill_nxt  = '0;
        last_nxt  = 1'b1;
        eob_nxt   = 1'b0;
        err_nxt   = ERR_NONE;
        state_nxt = ST_EMIT;
        priority if (item_r.litlen_code < EOB_CODE) begin
          win_req.we    = 1'b1;
          win_req.waddr = wpos_r;
          win_req.wdata = item_r.litlen_code[7:0];
          wpos_nxt      = wpos_r + ADDR_W'(1);
          seen_nxt      = seen_inc;
          lane_nxt[7:0] = item_r.litlen_code[7:0];
          fill_nxt      = FILL_W'(1);
        end else if (item_r.litlen_code == EOB_CODE) begin
          eob_nxt = 1'b1;
          if (item_r.final_block) begin
            wpos_nxt = '0;
            seen_nxt = '0;
          end
        end else if (item_r.litlen_code >= LEN_CODE_LIMIT) begin
          err_nxt = ERR_LEN_CODE;
        end else if (item_r.dist_code >= DIST_CODE_LIMIT) begin
          err_nxt = ERR_DIST_CODE;
        end else if (dist_far) begin
          err_nxt = ERR_DIST_FAR;
        end else begin
          last_nxt   = 1'b0;
          src_nxt    = src_start;
          remain_nxt = len_val;
          state_nxt  = ST_READ;
        end
      end

      ST_READ: begin
        win_req.re    = 1'b1;
        win_req.raddr = src_r;
        src_nxt       = src_r + ADDR_W'(1);
        state_nxt     = ST_WRITE;
      end

      ST_WRITE: begin
        win_req.we    = 1'b1;
        win_req.waddr = wpos_r;
        win_req.wdata = win_rdata;
        wpos_nxt      = wpos_r + ADDR_W'(1);
        seen_nxt      = seen_inc;
        lane_nxt[fill_r[LANE_IDX_W-1:0] * 8 +: 8] = win_rdata;
        fill_nxt      = fill_r + FILL_W'(1);
        remain_nxt    = remain_r - LEN_W'(1);
        priority if (remain_r == LEN_W'(1)) begin
          last_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else if (fill_r == FILL_W'(LANE_BYTES - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_READ;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_nxt.out_bytes    = lane_r;
          out_nxt.byte_count   = 4'(fill_r);
          out_nxt.last         = last_r;
          out_nxt.end_of_block = eob_r;
          out_nxt.error_code   = err_r;
          out_valid_nxt        = 1'b1;
          lane_nxt             = '0;
          fill_nxt             = '0;
          state_nxt            = last_r ? ST_IDLE : ST_READ;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wpos_r      <= '0;
      seen_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wpos_r      <= wpos_nxt;
      seen_r      <= seen_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and the output item.
  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    src_r    <= src_nxt;
    remain_r <= remain_nxt;
    lane_r   <= lane_nxt;
    last_r   <= last_nxt;
    eob_r    <= eob_nxt;
    err_r    <= err_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A window write of a copied byte always follows the read that fetched it.
  `IWCE_ASSERT(a_write_after_read, state_r == ST_WRITE |-> $past(state_r == ST_READ), "copy write without a preceding read")
  // The byte count never passes the window size.
  `IWCE_ASSERT(a_seen_bounded, seen_r <= SEEN_W'(WINDOW_SIZE), "bytes seen beyond window size")
  // The lane never holds more than a full item of bytes.
  `IWCE_ASSERT(a_fill_bounded, fill_r <= FILL_W'(LANE_BYTES), "lane overfilled")
  // Error and end-of-block items carry no bytes and close their token.
  `IWCE_ASSERT(a_empty_items, out_valid_r && (out_r.error_code != ERR_NONE || out_r.end_of_block) |-> out_r.byte_count == 4'd0 && out_r.last, "error or end marker with bytes")

endmodule
